// ===== hw/rtl/rmq_pkg.sv =====
`default_nettype none
package rmq_pkg;

   // Fixed-point format and derived widths
   localparam int FRAC_BITS  = 16;
   localparam int EW         = 18;                  // entry and component width
   localparam int NW         = EW + 1;              // entry pair sum or difference
   localparam int DW         = ((FRAC_BITS > EW - 1) ? FRAC_BITS : EW - 1) + 3;
   localparam int RW         = DW + FRAC_BITS;      // radicand width
   localparam int SW         = (RW + 1) / 2;        // root width, one root bit per stage
   localparam int PW         = 2 * SW;              // radicand padded to whole bit pairs
   localparam int DENW       = SW + 1;              // divisor 2R
   localparam int QW         = FRAC_BITS + 2;       // quotient bits kept before clamping
   localparam int DIV_STAGES = QW + 1;
   localparam int LATENCY    = SW + DIV_STAGES + 3;

   localparam longint ONE     = longint'(1) << FRAC_BITS;
   localparam longint OUT_MAX = (longint'(1) << (EW - 1)) - 1;
   localparam longint OUT_NEG = longint'(1) << (EW - 1);
   localparam longint POS_LIM = (ONE < OUT_MAX) ? ONE : OUT_MAX;
   localparam longint NEG_LIM = (ONE < OUT_NEG) ? ONE : OUT_NEG;

   typedef enum logic [1:0] {
      CASE_TRACE,
      CASE_X,
      CASE_Y,
      CASE_Z
   } case_type;

   // Per-request sideband that rides along the root pipeline
   typedef struct packed {
      case_type                cs;
      logic                    bad;
      logic signed [NW-1:0]    na;
      logic signed [NW-1:0]    nb;
      logic signed [NW-1:0]    nc;
   } side_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rmq_sqrt.sv =====
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [PW-1:0]   in_rad,
   input  wire side_type        in_side,
   output logic                 out_valid,
   output logic [SW-1:0]        out_root,
   output side_type             out_side
);

   logic            valid_ff [SW];
   logic [PW-1:0]   rad_ff   [SW];
   logic [SW+1:0]   rem_ff   [SW];
   logic [SW-1:0]   root_ff  [SW];
   side_type        side_ff  [SW];

   // One root bit per stage, restoring digit recurrence
   for (genvar i = 0; i < SW; i++) begin : g_step
      logic            valid_prev;
      logic [PW-1:0]   rad_prev;
      logic [SW+1:0]   rem_prev;
      logic [SW-1:0]   root_prev;
      side_type        side_prev;
      logic [SW+3:0]   cur;
      logic [SW+3:0]   trial;
      logic [SW+3:0]   diff;
      logic            fit;
      logic [SW+1:0]   rem_in;
      logic [SW-1:0]   root_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = in_rad;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rad_prev   = rad_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      assign cur     = {rem_prev, rad_prev[PW-1:PW-2]};
      assign trial   = {2'b00, root_prev, 2'b01};
      assign diff    = cur - trial;
      assign fit     = (cur >= trial);
      assign rem_in  = fit ? diff[SW+1:0] : cur[SW+1:0];
      assign root_in = {root_prev[SW-2:0], fit};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_prev;
         end
         rad_ff[i]  <= rad_prev << 2;
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         side_ff[i] <= side_prev;
      end
   end

   assign out_valid = valid_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_side  = side_ff[SW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div.sv =====
`default_nettype none
module rmq_div import rmq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic signed [NW-1:0]   num,
   input  wire logic [DENW-1:0]        den,
   output logic signed [EW-1:0]        quot
);

   localparam logic [QW-1:0] ONE_Q = QW'(ONE);
   localparam logic [QW-1:0] POS_Q = QW'(POS_LIM);
   localparam logic [QW-1:0] NEG_Q = QW'(NEG_LIM);

   logic                 neg_in;
   logic [NW-1:0]        mag_in;
   logic                 ovf_in;
   logic [DENW-1:0]      rem0_in;

   logic [DENW-1:0]      rem_ff  [QW];
   logic [QW-1:0]        q_ff    [QW];
   logic [DENW-1:0]      den_ff  [QW];
   logic [1:0]           low_ff  [QW];
   logic                 neg_ff  [QW];
   logic                 ovf_ff  [QW];
   logic signed [EW-1:0] quot_ff;

   // Split sign and magnitude; flag quotients of four or more
   assign neg_in  = num[NW-1];
   assign mag_in  = neg_in ? NW'(-num) : NW'(num);
   assign ovf_in  = ((DENW+2)'(mag_in) >= {den, 2'b00});
   assign rem0_in = DENW'(mag_in >> 2);

   // One quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DENW-1:0]  rem_prev;
      logic [QW-1:0]    q_prev;
      logic [DENW-1:0]  den_prev;
      logic [1:0]       low_prev;
      logic             neg_prev;
      logic             ovf_prev;
      logic             inbit;
      logic [DENW:0]    cur;
      logic [DENW:0]    diff;
      logic             fit;

      if (k == 0) begin : g_first
         assign rem_prev = rem0_in;
         assign q_prev   = '0;
         assign den_prev = den;
         assign low_prev = mag_in[1:0];
         assign neg_prev = neg_in;
         assign ovf_prev = ovf_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign neg_prev = neg_ff[k-1];
         assign ovf_prev = ovf_ff[k-1];
      end

      if (QW - 1 - k >= FRAC_BITS) begin : g_mag_bit
         assign inbit = low_prev[QW-1-k-FRAC_BITS];
      end else begin : g_zero_bit
         assign inbit = 1'b0;
      end

      assign cur  = {rem_prev, inbit};
      assign diff = cur - {1'b0, den_prev};
      assign fit  = (cur >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         rem_ff[k] <= fit ? diff[DENW-1:0] : cur[DENW-1:0];
         q_ff[k]   <= {q_prev[QW-2:0], fit};
         den_ff[k] <= den_prev;
         low_ff[k] <= low_prev;
         neg_ff[k] <= neg_prev;
         ovf_ff[k] <= ovf_prev;
      end
   end

   // Clamp to one, then to the output range, and apply the sign
   logic [QW-1:0]        mag_c;
   logic [QW-1:0]        mag_s;
   logic signed [QW:0]   sval;

   always_comb begin
      mag_c = (ovf_ff[QW-1] || (q_ff[QW-1] > ONE_Q)) ? ONE_Q : q_ff[QW-1];
      if (neg_ff[QW-1]) begin
         mag_s = (mag_c > NEG_Q) ? NEG_Q : mag_c;
         sval  = -$signed({1'b0, mag_s});
      end else begin
         mag_s = (mag_c > POS_Q) ? POS_Q : mag_c;
         sval  = $signed({1'b0, mag_s});
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= EW'(sval);
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, signed fixed point (Shepperd's method).
//
// Request channel: raise start with the nine entries on req_r00..req_r22; a
// request is taken at every rising edge where start is high and busy is low.
// busy stays low, so a new matrix may enter on every clock cycle.
// Result channel: rsp_valid is high for exactly one cycle with rsp_qx, rsp_qy,
// rsp_qz, rsp_qw, rsp_case_taken and rsp_invalid; results leave in request order.
// From the accepting edge to the result cycle the pipeline has one entry
// stage, 18 root stages (one root bit each), one stage forming 2R and R/2,
// 19 divider stages (18 quotient bits plus clamping), one output register.
// Throughput is one matrix per cycle; the three quotients run in parallel lanes.
// The receiver cannot stall; every result must be taken in its cycle.
// Reset (synchronous) clears all valid bits, dropping requests in flight;
// data registers are not reset.
// rsp_invalid marks a radicand that is not positive; components are then zero.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic signed [EW-1:0]  req_r00,
   input  wire logic signed [EW-1:0]  req_r01,
   input  wire logic signed [EW-1:0]  req_r02,
   input  wire logic signed [EW-1:0]  req_r10,
   input  wire logic signed [EW-1:0]  req_r11,
   input  wire logic signed [EW-1:0]  req_r12,
   input  wire logic signed [EW-1:0]  req_r20,
   input  wire logic signed [EW-1:0]  req_r21,
   input  wire logic signed [EW-1:0]  req_r22,
   output logic                       rsp_valid,
   output logic signed [EW-1:0]       rsp_qx,
   output logic signed [EW-1:0]       rsp_qy,
   output logic signed [EW-1:0]       rsp_qz,
   output logic signed [EW-1:0]       rsp_qw,
   output logic [1:0]                 rsp_case_taken,
   output logic                       rsp_invalid
);

   typedef struct packed {
      case_type         cs;
      logic             bad;
      logic [SW-2:0]    half;
   } tail_type;

   localparam logic [SW-2:0] HALF_LIM = (SW-1)'(POS_LIM);

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Entry stage: trace, case choice, radicand and numerator pairs
   logic signed [DW:0]    e00;
   logic signed [DW:0]    e11;
   logic signed [DW:0]    e22;
   logic signed [DW:0]    one_s;
   logic signed [DW:0]    trace;
   logic signed [DW:0]    d_in;
   case_type              cs_in;
   logic signed [NW-1:0]  p_xy;
   logic signed [NW-1:0]  p_xz;
   logic signed [NW-1:0]  p_yz;
   logic signed [NW-1:0]  m_x;
   logic signed [NW-1:0]  m_y;
   logic signed [NW-1:0]  m_z;
   side_type              side_in;
   logic [PW-1:0]         rad_in;

   always_comb begin
      e00   = (DW+1)'(req_r00);
      e11   = (DW+1)'(req_r11);
      e22   = (DW+1)'(req_r22);
      one_s = (DW+1)'(ONE);
      trace = e00 + e11 + e22;

      priority if (trace > 0) begin
         cs_in = CASE_TRACE;
         d_in  = one_s + trace;
      end else if ((e00 > e11) && (e00 > e22)) begin
         cs_in = CASE_X;
         d_in  = one_s + e00 - e11 - e22;
      end else if (e11 > e22) begin
         cs_in = CASE_Y;
         d_in  = one_s + e11 - e00 - e22;
      end else begin
         cs_in = CASE_Z;
         d_in  = one_s + e22 - e00 - e11;
      end

      p_xy = NW'(req_r01) + NW'(req_r10);
      p_xz = NW'(req_r02) + NW'(req_r20);
      p_yz = NW'(req_r12) + NW'(req_r21);
      m_x  = NW'(req_r21) - NW'(req_r12);
      m_y  = NW'(req_r02) - NW'(req_r20);
      m_z  = NW'(req_r10) - NW'(req_r01);

      side_in.cs  = cs_in;
      side_in.bad = (d_in <= 0);
      unique case (cs_in)
         CASE_TRACE: begin
            side_in.na = m_x;
            side_in.nb = m_y;
            side_in.nc = m_z;
         end
         CASE_X: begin
            side_in.na = p_xy;
            side_in.nb = p_xz;
            side_in.nc = m_x;
         end
         CASE_Y: begin
            side_in.na = p_xy;
            side_in.nb = p_yz;
            side_in.nc = m_y;
         end
         default: begin
            side_in.na = p_xz;
            side_in.nb = p_yz;
            side_in.nc = m_z;
         end
      endcase

      rad_in = side_in.bad ? '0 : PW'({d_in[DW-1:0], {FRAC_BITS{1'b0}}});
   end

   logic            a_valid_ff;
   logic [PW-1:0]   a_rad_ff;
   side_type        a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_rad_ff  <= rad_in;
      a_side_ff <= side_in;
   end

   // Square root pipeline
   logic            s_valid;
   logic [SW-1:0]   s_root;
   side_type        s_side;

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_rad    (a_rad_ff),
      .in_side   (a_side_ff),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // Form divisor 2R and dominant component R/2
   logic              b_valid_ff;
   logic [DENW-1:0]   b_den_ff;
   logic [SW-2:0]     b_half_ff;
   side_type          b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= s_valid;
      end
      b_den_ff  <= {s_root, 1'b0};
      b_half_ff <= s_root[SW-1:1];
      b_side_ff <= s_side;
   end

   // Three quotient lanes
   logic signed [EW-1:0] qa;
   logic signed [EW-1:0] qb;
   logic signed [EW-1:0] qc;

   rmq_div u_div_a (.clock(clock), .num(b_side_ff.na), .den(b_den_ff), .quot(qa));
   rmq_div u_div_b (.clock(clock), .num(b_side_ff.nb), .den(b_den_ff), .quot(qb));
   rmq_div u_div_c (.clock(clock), .num(b_side_ff.nc), .den(b_den_ff), .quot(qc));

   // Delay case, flag and R/2 alongside the divider lanes
   logic       t_valid_ff [DIV_STAGES];
   tail_type   t_ff       [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            t_valid_ff[i] <= 1'b0;
         end
      end else begin
         t_valid_ff[0] <= b_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            t_valid_ff[i] <= t_valid_ff[i-1];
         end
      end
      t_ff[0] <= '{cs: b_side_ff.cs, bad: b_side_ff.bad, half: b_half_ff};
      for (int i = 1; i < DIV_STAGES; i++) begin
         t_ff[i] <= t_ff[i-1];
      end
   end

   // Place lanes and R/2 by case; zero everything on a bad radicand
   tail_type              t_last;
   logic signed [EW-1:0]  hc;
   logic signed [EW-1:0]  qx_in;
   logic signed [EW-1:0]  qy_in;
   logic signed [EW-1:0]  qz_in;
   logic signed [EW-1:0]  qw_in;

   always_comb begin
      t_last = t_ff[DIV_STAGES-1];
      hc     = EW'((t_last.half > HALF_LIM) ? HALF_LIM : t_last.half);
      unique case (t_last.cs)
         CASE_TRACE: begin
            qx_in = qa;
            qy_in = qb;
            qz_in = qc;
            qw_in = hc;
         end
         CASE_X: begin
            qx_in = hc;
            qy_in = qa;
            qz_in = qb;
            qw_in = qc;
         end
         CASE_Y: begin
            qx_in = qa;
            qy_in = hc;
            qz_in = qb;
            qw_in = qc;
         end
         default: begin
            qx_in = qa;
            qy_in = qb;
            qz_in = hc;
            qw_in = qc;
         end
      endcase
      if (t_last.bad) begin
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
         qw_in = '0;
      end
   end

   logic                  rsp_valid_ff;
   logic signed [EW-1:0]  rsp_qx_ff;
   logic signed [EW-1:0]  rsp_qy_ff;
   logic signed [EW-1:0]  rsp_qz_ff;
   logic signed [EW-1:0]  rsp_qw_ff;
   case_type              rsp_case_ff;
   logic                  rsp_invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= t_valid_ff[DIV_STAGES-1];
      end
      rsp_qx_ff      <= qx_in;
      rsp_qy_ff      <= qy_in;
      rsp_qz_ff      <= qz_in;
      rsp_qw_ff      <= qw_in;
      rsp_case_ff    <= t_last.cs;
      rsp_invalid_ff <= t_last.bad;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_qx         = rsp_qx_ff;
   assign rsp_qy         = rsp_qy_ff;
   assign rsp_qz         = rsp_qz_ff;
   assign rsp_qw         = rsp_qw_ff;
   assign rsp_case_taken = rsp_case_ff;
   assign rsp_invalid    = rsp_invalid_ff;

   // A result only follows a request taken exactly one latency earlier
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without matching request");

   // A bad radicand gives all-zero components
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |->
         (rsp_qx == '0) && (rsp_qy == '0) && (rsp_qz == '0) && (rsp_qw == '0))
      else $error("invalid result with nonzero components");

   // In the trace case the scalar part qw, which holds R/2, is never negative
   a_dominant_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_case_taken == CASE_TRACE)) |-> !rsp_qw[EW-1])
      else $error("negative scalar part on positive trace");

endmodule
`default_nettype wire
